@@ sv/imh_pkg.sv @@
// ----------------------------------------------------------------------------
// imh_pkg: shared constants and types for the indexed min-heap
// Defaults for the heap depth and key width, and command codes.
// ----------------------------------------------------------------------------
package imh_pkg;
	localparam int unsigned MaxItemsDefault = 1024;
	localparam int unsigned KeyBitsDefault  = 32;
	localparam int unsigned CmdBits   = 2;
	localparam int unsigned ItemBits  = 10;
	localparam int unsigned KeyInBits = 32;
	localparam int unsigned CountBits = 11;
	localparam logic [CountBits-1:0] CountReset = 11'd1024;

	typedef enum logic [CmdBits-1:0] {
		CMD_LOAD    = 2'd0,
		CMD_BUILD   = 2'd1,
		CMD_EXTRACT = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;
endpackage

@@ sv/indexed_min_heap.sv @@
// ----------------------------------------------------------------------------
// indexed_min_heap: indexed binary min-heap over item numbers
// Sequencer around one shared key comparator; heap, keys and position map in
// single-port memories; heap and key reads are registered, the position map is only written.
// ----------------------------------------------------------------------------
// Steps: an extract moves the last entry to the root and sifts it down level by level;
// a build fills slot i with item i, then sifts each parent from the last one to the root.
// Throughput: one word at a time; ready is low while the sequencer works, set by
// the one compare unit and one memory port per store.
// The result word sits in an output register; a new word is taken while it waits.
// Reset empties the heap and sets count_q to 1024; memories are not cleared.
module indexed_min_heap
	import imh_pkg::*;
#(
	parameter int unsigned MAX_ITEMS = MaxItemsDefault,
	parameter int unsigned KEY_BITS  = KeyBitsDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CountBits-1:0] cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CmdBits-1:0]   cmd,
	input  logic [ItemBits-1:0]  item,
	input  logic [KeyInBits-1:0] key,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ItemBits-1:0]  min_item,
	output logic                 was_empty
);
	localparam int unsigned AW = $clog2(MAX_ITEMS);
	localparam int unsigned SW = AW + 1; // slot index with room for count

	typedef enum logic [4:0] {
		ST_IDLE, ST_BFILL, ST_BSTART,
		ST_XRD, ST_XWAIT, ST_XMV,
		ST_SD, ST_RDP, ST_RDL, ST_RDR, ST_KP, ST_KL, ST_KR, ST_KW,
		ST_DEC, ST_SW1, ST_SW2, ST_SW3,
		ST_OUT
	} state_t;

	// memories
	logic [KEY_BITS-1:0] key_mem [MAX_ITEMS];
	logic [AW-1:0]       heap_mem [MAX_ITEMS];
	logic [AW-1:0]       pos_mem [MAX_ITEMS];

	logic [AW-1:0]       key_addr, heap_addr, pos_addr;
	logic                key_we, heap_we, pos_we;
	logic [KEY_BITS-1:0] key_wd;
	logic [AW-1:0]       heap_wd, pos_wd;
	logic [KEY_BITS-1:0] key_rd_q;
	logic [AW-1:0]       heap_rd_q;

	always_ff @(posedge clk) begin
		if (key_we) key_mem[key_addr] <= key_wd;
		key_rd_q <= key_mem[key_addr];
	end
	always_ff @(posedge clk) begin
		if (heap_we) heap_mem[heap_addr] <= heap_wd;
		heap_rd_q <= heap_mem[heap_addr];
	end
	always_ff @(posedge clk) begin
		if (pos_we) pos_mem[pos_addr] <= pos_wd;
	end

	state_t              state_q;
	logic [CountBits-1:0] count_q;
	logic [SW-1:0]       size_q;      // occupied slots (last_slot + 1)
	logic [SW-1:0]       idx_q;       // build fill index / build root counter
	logic [SW-1:0]       slot_q;      // slot being sifted
	logic [SW-1:0]       best_q;
	logic                build_q;
	logic [AW-1:0]       pit_q, lit_q, rit_q, bit_q;
	logic [KEY_BITS-1:0] bkey_q;
	logic [AW-1:0]       top_q;
	logic                empty_pend_q; // pending result is the empty-heap word
	logic                out_valid_q, empty_q;
	logic [ItemBits-1:0] min_q;

	// child slots, wide enough never to wrap
	logic [SW:0] lc, rc;
	assign lc = {slot_q, 1'b1};
	assign rc = {slot_q, 1'b0} + {{SW{1'b0}}, 1'b0} + (SW+1)'(2);

	// shared compare unit: signed key read vs best key
	logic less;
	assign less = $signed(key_rd_q) < $signed(bkey_q);

	logic [SW-1:0] cnt_sat;
	assign cnt_sat = (SW'(count_q) > SW'(MAX_ITEMS)) ? SW'(MAX_ITEMS) : SW'(count_q);

	// a waiting result only holds back an extract at ST_OUT
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign min_item  = min_q;
	assign was_empty = empty_q;

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// memory port drive
	always_comb begin
		key_addr  = pit_q;
		key_we    = 1'b0;
		key_wd    = KEY_BITS'($signed(key));
		heap_addr = slot_q[AW-1:0];
		heap_we   = 1'b0;
		heap_wd   = idx_q[AW-1:0];
		pos_addr  = idx_q[AW-1:0];
		pos_we    = 1'b0;
		pos_wd    = idx_q[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				key_addr = AW'(item);
				key_we   = in_acc && (cmd_t'(cmd) == CMD_LOAD)
					&& (32'(item) < MAX_ITEMS);
				heap_addr = '0;
			end
			ST_BFILL: begin
				heap_addr = idx_q[AW-1:0];
				heap_we   = 1'b1;
				pos_we    = 1'b1;
			end
			ST_XRD, ST_XWAIT: heap_addr = AW'(size_q - SW'(1));
			ST_XMV: begin
				heap_addr = '0;
				heap_we   = 1'b1;
				heap_wd   = heap_rd_q;
				pos_addr  = heap_rd_q;
				pos_we    = 1'b1;
				pos_wd    = '0;
			end
			ST_RDP:   heap_addr = slot_q[AW-1:0];
			ST_RDL:   heap_addr = lc[AW-1:0];
			ST_RDR:   heap_addr = rc[AW-1:0];
			ST_KP:    key_addr = pit_q;
			ST_KL:    key_addr = lit_q;
			ST_KR:    key_addr = rit_q;
			ST_SW1: begin
				heap_addr = slot_q[AW-1:0];
				heap_we   = 1'b1;
				heap_wd   = bit_q;
				pos_addr  = bit_q;
				pos_we    = 1'b1;
				pos_wd    = slot_q[AW-1:0];
			end
			ST_SW2: begin
				heap_addr = best_q[AW-1:0];
				heap_we   = 1'b1;
				heap_wd   = pit_q;
				pos_addr  = pit_q;
				pos_we    = 1'b1;
				pos_wd    = best_q[AW-1:0];
			end
			default: ;
		endcase
	end

	// sequencer; sift reads parent, children, then their keys one by one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= CountReset;
			size_q       <= '0;
			idx_q        <= '0;
			slot_q       <= '0;
			best_q       <= '0;
			build_q      <= 1'b0;
			top_q        <= '0;
			empty_pend_q <= 1'b0;
			out_valid_q  <= 1'b0;
			empty_q      <= 1'b0;
			min_q        <= '0;
		end else begin
			if (cfg_we) count_q <= cfg_wdata;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (cmd_t'(cmd))
							CMD_BUILD: begin
								idx_q   <= '0;
								size_q  <= cnt_sat;
								build_q <= 1'b1;
								state_q <= (cnt_sat == '0) ? ST_IDLE : ST_BFILL;
							end
							CMD_EXTRACT: begin
								if (size_q == '0) begin
									// report empty once the output register is free
									top_q        <= '0;
									empty_pend_q <= 1'b1;
									state_q      <= ST_OUT;
								end else begin
									build_q      <= 1'b0;
									empty_pend_q <= 1'b0;
									state_q      <= ST_XRD;
								end
							end
							default: ;
						endcase
					end
				end
				ST_BFILL: begin
					// write slot i = item i, then start sifting from the last parent
					if (idx_q + SW'(1) == size_q) begin
						idx_q   <= ((size_q - SW'(1)) >> 1) + SW'(1);
						state_q <= ST_BSTART;
					end else begin
						idx_q <= idx_q + SW'(1);
					end
				end
				ST_BSTART: begin
					if (idx_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q   <= idx_q - SW'(1);
						slot_q  <= idx_q - SW'(1);
						state_q <= ST_RDP;
					end
				end
				ST_XRD: begin
					// heap_rd_q now holds the root item
					top_q   <= heap_rd_q;
					state_q <= ST_XWAIT;
				end
				ST_XWAIT: begin
					// hold the last-slot read for the move
					state_q <= ST_XMV;
				end
				ST_XMV: begin
					size_q  <= size_q - SW'(1);
					slot_q  <= '0;
					state_q <= ST_RDP;
				end
				ST_RDP: state_q <= ST_RDL;
				ST_RDL: begin
					pit_q   <= heap_rd_q;
					state_q <= ST_RDR;
				end
				ST_RDR: begin
					lit_q   <= heap_rd_q;
					state_q <= ST_KP;
				end
				ST_KP: begin
					rit_q   <= heap_rd_q;
					state_q <= ST_KL;
				end
				ST_KL: begin
					// parent key ready
					bkey_q  <= key_rd_q;
					best_q  <= slot_q;
					bit_q   <= pit_q;
					state_q <= ST_KR;
				end
				ST_KR: begin
					if ((lc < (SW+1)'(size_q)) && less) begin
						bkey_q <= key_rd_q;
						best_q <= lc[SW-1:0];
						bit_q  <= lit_q;
					end
					state_q <= ST_KW;
				end
				ST_KW: begin
					if ((rc < (SW+1)'(size_q)) && less) begin
						best_q <= rc[SW-1:0];
						bit_q  <= rit_q;
					end
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					state_q <= (best_q == slot_q) ? ST_SW3 : ST_SW1;
				end
				ST_SW1: state_q <= ST_SW2;
				ST_SW2: begin
					slot_q  <= best_q;
					state_q <= ST_RDP;
				end
				ST_SW3: begin
					// sift step done
					state_q <= build_q ? ST_BSTART : ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q) begin
						min_q       <= ItemBits'(top_q);
						empty_q     <= empty_pend_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ verif/tb_indexed_min_heap.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_min_heap: self-checking bench for the indexed min-heap
// Loads keys, builds heaps of many sizes and extracts them, while both sides
// idle at random. A shadow heap predicts every extracted word, and a checker
// compares each output word with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_indexed_min_heap;
	import imh_pkg::*;

	localparam int unsigned Depth = MaxItemsDefault;

	typedef struct packed {
		logic [ItemBits-1:0] item;
		logic                empty;
	} heap_word_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CountBits-1:0] cfg_wdata;
	logic                 in_valid;
	logic                 in_ready;
	logic [CmdBits-1:0]   cmd;
	logic [ItemBits-1:0]  item;
	logic [KeyInBits-1:0] key;
	logic                 out_valid;
	logic                 out_ready;
	logic [ItemBits-1:0]  min_item;
	logic                 was_empty;

	// Snapshots taken at the falling edge; outputs only move on rising edges,
	// so these hold the values that the next rising edge will see.
	logic                in_rdy_s;
	logic                out_vld_s;
	logic [ItemBits-1:0] min_item_s;
	logic                was_empty_s;

	// Shadow heap state
	logic signed [KeyInBits-1:0] shadow_keys [Depth];
	logic [ItemBits-1:0]         shadow_slots[Depth];
	logic [ItemBits-1:0]         shadow_pos  [Depth];
	int                          shadow_last;
	int unsigned                 shadow_count;

	heap_word_t extract_q[$];
	int         errors;
	int         items_sent;
	int         words_checked;
	int         builds_done;
	int         empty_seen;
	int         hold_req;
	bit         quiet;

	indexed_min_heap u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .item(item), .key(key),
		.out_valid(out_valid), .out_ready(out_ready),
		.min_item(min_item), .was_empty(was_empty)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk) begin
		in_rdy_s    = in_ready;
		out_vld_s   = out_valid;
		min_item_s  = min_item;
		was_empty_s = was_empty;
	end

	// ---------------- shadow heap ----------------
	function automatic bit key_lt(input logic [ItemBits-1:0] a, input logic [ItemBits-1:0] b);
		return shadow_keys[a] < shadow_keys[b];
	endfunction

	function automatic void sift_from(input int start);
		int s;
		int best;
		int lc;
		int rc;
		logic [ItemBits-1:0] t;
		s = start;
		forever begin
			if (shadow_last < 0) return;
			best = s;
			lc = 2 * s + 1;
			rc = 2 * s + 2;
			if (lc <= shadow_last && key_lt(shadow_slots[lc], shadow_slots[best])) best = lc;
			if (rc <= shadow_last && key_lt(shadow_slots[rc], shadow_slots[best])) best = rc;
			if (best == s) return;
			shadow_pos[shadow_slots[s]]    = best[ItemBits-1:0];
			shadow_pos[shadow_slots[best]] = s[ItemBits-1:0];
			t = shadow_slots[s];
			shadow_slots[s] = shadow_slots[best];
			shadow_slots[best] = t;
			s = best;
		end
	endfunction

	function automatic void heap_apply(input cmd_t c, input logic [ItemBits-1:0] it,
			input logic [KeyInBits-1:0] k);
		int n;
		heap_word_t w;
		case (c)
			CMD_LOAD: begin
				shadow_keys[it] = k;
			end
			CMD_BUILD: begin
				n = (shadow_count > Depth) ? Depth : shadow_count;
				for (int i = 0; i < n; i++) begin
					shadow_slots[i] = i[ItemBits-1:0];
					shadow_pos[i]   = i[ItemBits-1:0];
				end
				shadow_last = n - 1;
				if (n > 0)
					for (int i = (n - 1) / 2; i >= 0; i--) sift_from(i);
			end
			CMD_EXTRACT: begin
				if (shadow_last < 0) begin
					w.item  = '0;
					w.empty = 1'b1;
				end else begin
					w.item  = shadow_slots[0];
					w.empty = 1'b0;
					shadow_slots[0] = shadow_slots[shadow_last];
					shadow_pos[shadow_slots[0]] = '0;
					shadow_last--;
					sift_from(0);
				end
				extract_q.push_back(w);
			end
			default: ;
		endcase
	endfunction

	// ---------------- sender ----------------
	// Call on a rising edge; returns on the edge that accepts the word.
	task automatic send_word(input cmd_t c, input logic [ItemBits-1:0] it,
			input logic [KeyInBits-1:0] k);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		item     <= it;
		key      <= k;
		do @(posedge clk); while (!in_rdy_s);
		heap_apply(c, it, k);
		items_sent++;
		if (c == CMD_BUILD) builds_done++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (extract_q.size() != 0) @(posedge clk);
		// a build may still be busy with no word owed
		repeat (8) @(posedge clk);
		while (!in_rdy_s) @(posedge clk);
	endtask

	task automatic write_count(input logic [CountBits-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_count = v;
	endtask

	function automatic logic [KeyInBits-1:0] pick_key();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return {16'($urandom_range(0, 7)), 16'h0};
			default: return $urandom();
		endcase
	endfunction

	// ---------------- checker ----------------
	initial begin : check_proc
		int stall;
		heap_word_t w;
		out_ready = 1'b0;
		forever begin
			if (hold_req > 0) begin
				stall = hold_req;
				hold_req = 0;
			end else begin
				stall = quiet ? 0 : $urandom_range(0, 4);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_vld_s);
			words_checked++;
			if (extract_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word item=%0d empty=%0b", $time,
					min_item_s, was_empty_s);
			end else begin
				w = extract_q.pop_front();
				if (w.empty) empty_seen++;
				if (w.item !== min_item_s) begin
					errors++;
					$display("%0t: min_item expected %0d actual %0d", $time,
						w.item, min_item_s);
				end
				if (w.empty !== was_empty_s) begin
					errors++;
					$display("%0t: was_empty expected %0b actual %0b", $time,
						w.empty, was_empty_s);
				end
			end
		end
	end

	// ---------------- tests ----------------
	// Extremes, ties, empty heap, unused command, zero count.
	task automatic test_directed();
		write_count(11'd4);
		send_word(CMD_EXTRACT, 10'd0, '0);
		send_word(CMD_LOAD, 10'd0, 32'h7FFF_FFFF);
		send_word(CMD_LOAD, 10'd1, 32'h8000_0000);
		send_word(CMD_LOAD, 10'd2, 32'h0001_0000);
		send_word(CMD_LOAD, 10'd3, 32'h0001_0000);
		send_word(CMD_LOAD, 10'd1023, 32'hFFFF_FFFF);
		send_word(CMD_NONE, 10'h3FF, 32'hFFFF_FFFF);
		send_word(CMD_BUILD, 10'd0, '0);
		repeat (5) send_word(CMD_EXTRACT, 10'd0, '0);
		// equal keys everywhere: ties keep parent order
		send_word(CMD_LOAD, 10'd1, 32'h0001_0000);
		send_word(CMD_LOAD, 10'd0, 32'h0001_0000);
		send_word(CMD_BUILD, 10'd0, '0);
		send_word(CMD_EXTRACT, 10'd0, '0);
		// rebuild mid-heap discards contents
		send_word(CMD_BUILD, 10'd0, '0);
		repeat (2) send_word(CMD_EXTRACT, 10'd0, '0);
		write_count(11'd0);
		send_word(CMD_BUILD, 10'd0, '0);
		send_word(CMD_EXTRACT, 10'd0, '0);
	endtask

	// Load every key, then build at full size and with a saturating count.
	task automatic test_full_heap();
		write_count(11'd1024);
		for (int i = 0; i < Depth; i++) send_word(CMD_LOAD, i[ItemBits-1:0], pick_key());
		send_word(CMD_BUILD, 10'd0, '0);
		repeat (20) send_word(CMD_EXTRACT, 10'd0, '0);
		write_count(11'h7FF);
		send_word(CMD_BUILD, 10'd0, '0);
		repeat (10) send_word(CMD_EXTRACT, 10'd0, '0);
	endtask

	// Hold off the output while extracts queue up, then pause until drained.
	task automatic test_backpressure();
		write_count(11'd40);
		send_word(CMD_BUILD, 10'd0, '0);
		hold_req = 300;
		repeat (12) send_word(CMD_EXTRACT, 10'd0, '0);
		in_valid <= 1'b0;
		while (extract_q.size() != 0) @(posedge clk);
		repeat (10) send_word(CMD_EXTRACT, 10'd0, '0);
	endtask

	task automatic test_random();
		int ops;
		int r;
		logic [CountBits-1:0] cnt;
		while (items_sent < 1850) begin
			r = $urandom_range(0, 19);
			if (r == 0) cnt = 11'd1;
			else if (r == 1) cnt = 11'd1024;
			else if (r == 2) cnt = CountBits'($urandom_range(1025, 2047));
			else if (r == 3) cnt = 11'd0;
			else cnt = CountBits'($urandom_range(2, 40));
			write_count(cnt);
			quiet = ($urandom_range(0, 3) == 0);
			send_word(CMD_BUILD, 10'd0, '0);
			ops = $urandom_range(10, 60);
			repeat (ops) begin
				r = $urandom_range(0, 99);
				if (r < 65) send_word(CMD_EXTRACT, ItemBits'($urandom()), $urandom());
				else if (r < 90) send_word(CMD_LOAD, ItemBits'($urandom()), pick_key());
				else if (r < 95) send_word(CMD_NONE, ItemBits'($urandom()), $urandom());
				else if (cnt <= 64) send_word(CMD_BUILD, ItemBits'($urandom()), $urandom());
				else send_word(CMD_EXTRACT, 10'd0, '0);
			end
			quiet = 1'b0;
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		cmd       = CMD_NONE;
		item      = '0;
		key       = '0;
		errors = 0; items_sent = 0; words_checked = 0; builds_done = 0;
		empty_seen = 0; hold_req = 0; quiet = 1'b0;
		for (int i = 0; i < Depth; i++) begin
			shadow_keys[i] = '0;
			shadow_slots[i] = '0;
			shadow_pos[i] = '0;
		end
		shadow_last  = -1;
		shadow_count = CountReset;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_heap();
		test_backpressure();
		test_random();

		drain();
		repeat (100) @(posedge clk);
		$display("Sent %0d words (%0d builds), checked %0d extract results (%0d empty).",
			items_sent, builds_done, words_checked, empty_seen);
		if (errors == 0 && extract_q.size() == 0) begin
			$display("[indexed_min_heap] OK");
		end else begin
			$display("%0t: %0d mismatches, %0d results still owed", $time,
				errors, extract_q.size());
			$display("[indexed_min_heap] ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("%0t: timeout", $time);
		$display("[indexed_min_heap] ERROR");
		$finish;
	end
endmodule
